FILE: hw/rtl/lz4_block_decoder_assert.svh
// Assertion macros used by the decoder checker.
`ifndef LZ4_BLOCK_DECODER_ASSERT_SVH
`define LZ4_BLOCK_DECODER_ASSERT_SVH

// Same-cycle implication, clocked on i_clk, off while i_rst_n is low.
`define LZ4BD_ASSERT_IMPL(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("lz4bd checker: assertion failed");

// Next-cycle implication, clocked on i_clk, off while i_rst_n is low.
`define LZ4BD_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("lz4bd checker: assertion failed");

`endif

FILE: hw/rtl/lz4bd_pkg.sv
// Types and constants of the LZ4 block decoder.
`default_nettype none
package lz4bd_pkg;

    typedef enum logic [2:0] {
        PH_TOKEN,
        PH_LITEXT,
        PH_LIT,
        PH_OFFLO,
        PH_OFFHI,
        PH_MATCHEXT,
        PH_COPY,
        PH_HALT
    } t_phase;

    typedef enum logic [1:0] {
        ST_RUN,
        ST_DONE_EXACT,
        ST_ZERO_OFFSET,
        ST_DONE_OVERRUN
    } t_status;

    localparam logic       OP_BYTE    = 1'b0;
    localparam logic       OP_ADVANCE = 1'b1;

    localparam logic [3:0] NIBBLE_EXT = 4'hF;
    localparam logic [7:0] BYTE_EXT   = 8'hFF;
    localparam logic [31:0] MATCH_MIN = 32'd4;

    localparam int OUT_DATA_W     = 16;
    localparam int OUT_VALID_BIT  = 0;
    localparam int OUT_BYTE_LO    = 1;
    localparam int OUT_ACC_BIT    = 9;
    localparam int OUT_PEND_BIT   = 10;
    localparam int OUT_STATUS_LO  = 11;

endpackage
`default_nettype wire

FILE: hw/rtl/lz4_block_decoder.sv
// Top level of the LZ4 raw-block decoder.
`default_nettype none
// Decodes one LZ4 raw block fed a byte per request on the slave stream (tuser
// 0 offers a compressed byte, tuser 1 advances one pending match copy byte) and
// returns exactly one result per request on the master stream. One request is
// taken every cycle while the master stream does not stall; each result passes
// a pipeline register, loaded with the control update and the window read, then
// the output register, loaded as the byte is formed and written into the 64 KiB
// window memory. The byte written in the previous cycle is forwarded to the
// copy path, so offsets of 1 to 3 run at full rate. The window is not cleared
// after reset; matches that reach before the first decoded byte return
// undefined data. Write output_total only while no request is in flight.
module lz4_block_decoder
    import lz4bd_pkg::*;
#(
    parameter int WINDOW_ADDR_BITS = 16
) (
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire logic                  i_cfg_we,
    input  wire logic [31:0]           i_cfg_wdata,
    input  wire logic                  i_s_tvalid,
    output logic                       o_s_tready,
    input  wire logic [7:0]            i_s_tdata,   // compressed_byte
    input  wire logic                  i_s_tuser,   // operation
    output logic                       o_m_tvalid,
    input  wire logic                  i_m_tready,
    // out_valid, out_byte[7:0], accepted, copy_pending, status[1:0], zero pad
    output logic [OUT_DATA_W-1:0]      o_m_tdata
);

    localparam int AW = WINDOW_ADDR_BITS;

    function automatic logic [31:0] sat_add(input logic [31:0] a, input logic [31:0] b);
        logic [32:0] s;
        s = {1'b0, a} + {1'b0, b};
        return s[32] ? 32'hFFFF_FFFF : s[31:0];
    endfunction

    logic [31:0] r_output_total;
    t_phase      r_phase, n_phase;
    logic [31:0] r_lrem, n_lrem;
    logic [31:0] r_mrem, n_mrem;
    logic [3:0]  r_nib, n_nib;
    logic [15:0] r_off, n_off;
    logic [15:0] r_src, n_src;
    logic [31:0] r_count, n_count;
    t_status     r_fin, n_fin;

    logic          r_p_valid;
    logic          r_p_write;
    logic          r_p_copy;
    logic          r_p_fwd;
    logic [7:0]    r_p_lit;
    logic          r_p_acc;
    logic          r_p_pend;
    t_status       r_p_status;
    logic [AW-1:0] r_p_waddr;
    logic [7:0]    r_fwd_data;

    logic                  r_o_valid;
    logic [OUT_DATA_W-1:0] r_o_data;

    logic        accept, out_free, p_move;
    logic        put, pre_ge, pre_eq, new_ge, new_eq, run;
    logic [31:0] cnt_new;
    logic        s_write, s_copy, s_acc, s_pend;
    logic [7:0]  rd_data, p_byte;
    logic [31:0] m_ext;
    logic [15:0] off_new;

    assign out_free   = !r_o_valid || i_m_tready;
    assign p_move     = r_p_valid && out_free;
    assign o_s_tready = !r_p_valid || out_free;
    assign accept     = i_s_tvalid && o_s_tready;

    assign put     = (r_fin == ST_RUN) &&
                     ((i_s_tuser == OP_ADVANCE && r_phase == PH_COPY) ||
                      (i_s_tuser == OP_BYTE && r_phase == PH_LIT));
    assign cnt_new = r_count + {31'd0, put};
    assign pre_ge  = r_count >= r_output_total;
    assign pre_eq  = r_count == r_output_total;
    assign new_ge  = cnt_new >= r_output_total;
    assign new_eq  = cnt_new == r_output_total;
    assign run     = (r_fin == ST_RUN) && !(r_phase == PH_TOKEN && pre_ge);
    assign m_ext   = sat_add(r_mrem, {24'd0, i_s_tdata});
    assign off_new = {i_s_tdata, r_off[7:0]};

    // next state
    always_comb begin
        n_phase = r_phase;
        n_lrem  = r_lrem;
        n_mrem  = r_mrem;
        n_nib   = r_nib;
        n_off   = r_off;
        n_src   = r_src;
        n_count = r_count;
        n_fin   = r_fin;
        if (!run && r_fin == ST_RUN) begin
            n_fin   = pre_eq ? ST_DONE_EXACT : ST_DONE_OVERRUN;
            n_phase = PH_HALT;
        end
        if (run) begin
            if (i_s_tuser == OP_ADVANCE) begin
                if (r_phase == PH_COPY) begin
                    n_count = cnt_new;
                    n_src   = r_src + 16'd1;
                    n_mrem  = r_mrem - 32'd1;
                    if (r_mrem == 32'd1) begin
                        n_phase = PH_TOKEN;
                    end
                end
            end else begin
                unique case (r_phase)
                    PH_TOKEN: begin
                        n_nib  = i_s_tdata[3:0];
                        n_lrem = {28'd0, i_s_tdata[7:4]};
                        if (i_s_tdata[7:4] == NIBBLE_EXT) begin
                            n_phase = PH_LITEXT;
                        end else if (i_s_tdata[7:4] != 4'd0) begin
                            n_phase = PH_LIT;
                        end else if (new_ge) begin
                            n_fin   = new_eq ? ST_DONE_EXACT : ST_DONE_OVERRUN;
                            n_phase = PH_HALT;
                        end else begin
                            n_phase = PH_OFFLO;
                        end
                    end
                    PH_LITEXT: begin
                        n_lrem = sat_add(r_lrem, {24'd0, i_s_tdata});
                        if (i_s_tdata != BYTE_EXT) begin
                            n_phase = PH_LIT;
                        end
                    end
                    PH_LIT: begin
                        n_count = cnt_new;
                        n_lrem  = r_lrem - 32'd1;
                        if (r_lrem == 32'd1) begin
                            if (new_ge) begin
                                n_fin   = new_eq ? ST_DONE_EXACT : ST_DONE_OVERRUN;
                                n_phase = PH_HALT;
                            end else begin
                                n_phase = PH_OFFLO;
                            end
                        end
                    end
                    PH_OFFLO: begin
                        n_off   = {8'd0, i_s_tdata};
                        n_phase = PH_OFFHI;
                    end
                    PH_OFFHI: begin
                        n_off = off_new;
                        if (off_new == 16'd0) begin
                            n_fin   = ST_ZERO_OFFSET;
                            n_phase = PH_HALT;
                        end else if (r_nib == NIBBLE_EXT) begin
                            n_mrem  = {28'd0, NIBBLE_EXT};
                            n_phase = PH_MATCHEXT;
                        end else begin
                            n_mrem  = {28'd0, r_nib} + MATCH_MIN;
                            n_src   = r_count[15:0] - off_new;
                            n_phase = PH_COPY;
                        end
                    end
                    PH_MATCHEXT: begin
                        n_mrem = m_ext;
                        if (i_s_tdata != BYTE_EXT) begin
                            n_mrem  = sat_add(m_ext, MATCH_MIN);
                            n_src   = r_count[15:0] - r_off;
                            n_phase = PH_COPY;
                        end
                    end
                    default: begin
                    end
                endcase
            end
        end
        if (n_fin == ST_RUN && n_phase == PH_TOKEN && new_ge) begin
            n_fin   = new_eq ? ST_DONE_EXACT : ST_DONE_OVERRUN;
            n_phase = PH_HALT;
        end
    end

    // step outputs
    always_comb begin
        s_write = put;
        s_copy  = run && i_s_tuser == OP_ADVANCE && r_phase == PH_COPY;
        s_acc   = run && i_s_tuser == OP_BYTE && r_phase != PH_COPY && r_phase != PH_HALT;
        s_pend  = n_phase == PH_COPY && n_fin == ST_RUN;
    end

    lz4bd_window #(
        .ADDR_BITS (AW)
    ) u_window (
        .i_clk   (i_clk),
        .i_we    (p_move && r_p_write),
        .i_waddr (r_p_waddr),
        .i_wdata (p_byte),
        .i_re    (accept),
        .i_raddr (r_src[AW-1:0]),
        .o_rdata (rd_data)
    );

    assign p_byte = r_p_copy ? (r_p_fwd ? r_fwd_data : rd_data) : r_p_lit;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_output_total <= 32'd0;
        end else if (i_cfg_we) begin
            r_output_total <= i_cfg_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= PH_TOKEN;
            r_lrem  <= 32'd0;
            r_mrem  <= 32'd0;
            r_nib   <= 4'd0;
            r_off   <= 16'd0;
            r_src   <= 16'd0;
            r_count <= 32'd0;
            r_fin   <= ST_RUN;
        end else if (accept) begin
            r_phase <= n_phase;
            r_lrem  <= n_lrem;
            r_mrem  <= n_mrem;
            r_nib   <= n_nib;
            r_off   <= n_off;
            r_src   <= n_src;
            r_count <= n_count;
            r_fin   <= n_fin;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_p_valid <= 1'b0;
        end else if (accept) begin
            r_p_valid <= 1'b1;
        end else if (p_move) begin
            r_p_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_p_write  <= s_write;
            r_p_copy   <= s_copy;
            r_p_fwd    <= p_move && r_p_write && (r_p_waddr == r_src[AW-1:0]);
            r_fwd_data <= p_byte;
            r_p_lit    <= i_s_tdata;
            r_p_acc    <= s_acc;
            r_p_pend   <= s_pend;
            r_p_status <= n_fin;
            r_p_waddr  <= r_count[AW-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_o_valid <= 1'b0;
        end else if (p_move) begin
            r_o_valid <= 1'b1;
        end else if (i_m_tready) begin
            r_o_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (p_move) begin
            r_o_data <= {3'd0, r_p_status, r_p_pend, r_p_acc,
                         (r_p_write ? p_byte : 8'd0), r_p_write};
        end
    end

    assign o_m_tvalid = r_o_valid;
    assign o_m_tdata  = r_o_data;

endmodule
`default_nettype wire

FILE: hw/rtl/lz4bd_window.sv
// Decoded-byte window: one write port, one registered read port.
`default_nettype none
module lz4bd_window #(
    parameter int ADDR_BITS = 16
) (
    input  wire logic                 i_clk,
    input  wire logic                 i_we,
    input  wire logic [ADDR_BITS-1:0] i_waddr,
    input  wire logic [7:0]           i_wdata,
    input  wire logic                 i_re,
    input  wire logic [ADDR_BITS-1:0] i_raddr,
    output logic      [7:0]           o_rdata
);

    logic [7:0] r_mem [2**ADDR_BITS];
    logic [7:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule
`default_nettype wire

FILE: hw/rtl/lz4bd_checker.sv
// Port-level checker of the LZ4 block decoder and its bind.
`default_nettype none
`include "lz4_block_decoder_assert.svh"
module lz4bd_checker
    import lz4bd_pkg::*;
(
    input wire logic                  i_clk,
    input wire logic                  i_rst_n,
    input wire logic                  o_m_tvalid,
    input wire logic                  i_m_tready,
    input wire logic [OUT_DATA_W-1:0] o_m_tdata
);

    logic       deliver;
    logic       out_valid, out_acc, out_pend;
    logic [7:0] out_byte;
    logic [1:0] out_status;
    logic       fin_quiet;
    logic       r_seen_fin;
    logic [1:0] r_last_status;

    assign deliver    = o_m_tvalid && i_m_tready;
    assign out_valid  = o_m_tdata[OUT_VALID_BIT];
    assign out_byte   = o_m_tdata[OUT_BYTE_LO +: 8];
    assign out_acc    = o_m_tdata[OUT_ACC_BIT];
    assign out_pend   = o_m_tdata[OUT_PEND_BIT];
    assign out_status = o_m_tdata[OUT_STATUS_LO +: 2];
    assign fin_quiet  = (out_status == r_last_status) && !out_valid && !out_acc;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_seen_fin    <= 1'b0;
            r_last_status <= ST_RUN;
        end else if (deliver && out_status != ST_RUN) begin
            r_seen_fin    <= 1'b1;
            r_last_status <= out_status;
        end
    end

    `LZ4BD_ASSERT_NEXT(a_out_hold, o_m_tvalid && !i_m_tready, o_m_tvalid && $stable(o_m_tdata))
    `LZ4BD_ASSERT_IMPL(a_idle_byte_zero, deliver && !out_valid, out_byte == 8'd0)
    `LZ4BD_ASSERT_IMPL(a_status_sticky, deliver && r_seen_fin, fin_quiet)
    `LZ4BD_ASSERT_IMPL(a_literal_no_copy, deliver && out_valid && out_acc, !out_pend)

endmodule

bind lz4_block_decoder lz4bd_checker u_lz4bd_checker (.*);
`default_nettype wire

FILE: tb/sv/lz4_block_decoder_tb.sv
// Self-checking testbench for the LZ4 block decoder with a built-in decode predictor.
`default_nettype none
module lz4_block_decoder_tb;
    import lz4bd_pkg::*;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int CYCLE_LIMIT = 400000;

    typedef enum int {END_EXACT, END_OVERRUN, END_ZERO_OFFSET, END_CLEAR_TOTAL} t_end_kind;

    typedef struct {
        logic       op;
        logic [7:0] data;
    } t_lz4_req;

    typedef struct {
        logic       out_valid;
        logic [7:0] out_byte;
        logic       accepted;
        logic       copy_pending;
        t_status    status;
    } t_lz4_result;

    logic                  i_clk = 1'b0;
    logic                  i_rst_n = 1'b0;
    logic                  i_cfg_we = 1'b0;
    logic [31:0]           i_cfg_wdata = '0;
    logic                  i_s_tvalid = 1'b0;
    logic                  o_s_tready;
    logic [7:0]            i_s_tdata = '0;
    logic                  i_s_tuser = 1'b0;
    logic                  o_m_tvalid;
    logic                  i_m_tready = 1'b0;
    logic [OUT_DATA_W-1:0] o_m_tdata;

    lz4_block_decoder i_dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_wdata(i_cfg_wdata),
        .i_s_tvalid (i_s_tvalid),
        .o_s_tready (o_s_tready),
        .i_s_tdata  (i_s_tdata),
        .i_s_tuser  (i_s_tuser),
        .o_m_tvalid (o_m_tvalid),
        .i_m_tready (i_m_tready),
        .o_m_tdata  (o_m_tdata)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    t_lz4_req    compressed_stream[$];
    t_lz4_result results_due[$];
    t_lz4_req    cur_req;

    int errors = 0;
    int cycles = 0;
    int real_reqs = 0;
    int accepted_reqs = 0;
    int cfg_writes = 0;
    int sequences = 0;
    int gen_count = 0;
    int burst_left = 0;
    int gap_left = 0;
    int stall_tick = 0;
    int stall_mode = 0;
    bit drive_busy = 1'b0;

    // decode predictor state
    logic [31:0] total_reg = '0;
    t_phase      ph = PH_TOKEN;
    logic [31:0] lit_left = '0;
    logic [31:0] match_left = '0;
    logic [3:0]  low_nib = '0;
    logic [15:0] offs = '0;
    logic [15:0] src = '0;
    logic [31:0] produced = '0;
    t_status     fin_st = ST_RUN;
    logic [7:0]  window_copy [0:65535];

    task log_mismatch(input string msg);
        errors++;
        $display("ERROR @%0t: %s", $time, msg);
    endtask

    function automatic logic [31:0] sat_add(input logic [31:0] a, input logic [31:0] b);
        logic [32:0] s;
        s = {1'b0, a} + {1'b0, b};
        return s[32] ? 32'hFFFF_FFFF : s[31:0];
    endfunction

    task finish_count;
        fin_st = (produced == total_reg) ? ST_DONE_EXACT : ST_DONE_OVERRUN;
        ph = PH_HALT;
    endtask

    task close_if_done;
        if (fin_st == ST_RUN && ph == PH_TOKEN && produced >= total_reg) finish_count();
    endtask

    task end_literals;
        if (produced >= total_reg) finish_count();
        else ph = PH_OFFLO;
    endtask

    task start_copy(input logic [31:0] len);
        match_left = sat_add(len, MATCH_MIN);
        src = produced[15:0] - offs;
        ph = PH_COPY;
    endtask

    task put_byte(input logic [7:0] b);
        window_copy[produced[15:0]] = b;
        produced = produced + 1;
    endtask

    task decode_step(input logic op, input logic [7:0] b);
        t_lz4_result r;
        r.out_valid = 1'b0;
        r.out_byte = '0;
        r.accepted = 1'b0;
        close_if_done();
        if (fin_st == ST_RUN) begin
            if (op == OP_ADVANCE) begin
                if (ph == PH_COPY) begin
                    r.out_byte = window_copy[src];
                    r.out_valid = 1'b1;
                    put_byte(r.out_byte);
                    src = src + 1;
                    match_left = match_left - 1;
                    if (match_left == 0) ph = PH_TOKEN;
                end
            end else if (ph != PH_COPY) begin
                r.accepted = 1'b1;
                case (ph)
                    PH_TOKEN: begin
                        low_nib = b[3:0];
                        lit_left = {28'd0, b[7:4]};
                        if (b[7:4] == NIBBLE_EXT) ph = PH_LITEXT;
                        else if (b[7:4] != 4'd0) ph = PH_LIT;
                        else end_literals();
                    end
                    PH_LITEXT: begin
                        lit_left = sat_add(lit_left, {24'd0, b});
                        if (b != BYTE_EXT) ph = PH_LIT;
                    end
                    PH_LIT: begin
                        put_byte(b);
                        r.out_valid = 1'b1;
                        r.out_byte = b;
                        lit_left = lit_left - 1;
                        if (lit_left == 0) end_literals();
                    end
                    PH_OFFLO: begin
                        offs = {8'h00, b};
                        ph = PH_OFFHI;
                    end
                    PH_OFFHI: begin
                        offs = {b, offs[7:0]};
                        if (offs == 16'd0) begin
                            fin_st = ST_ZERO_OFFSET;
                            ph = PH_HALT;
                        end else if (low_nib == NIBBLE_EXT) begin
                            match_left = {28'd0, NIBBLE_EXT};
                            ph = PH_MATCHEXT;
                        end else begin
                            start_copy({28'd0, low_nib});
                        end
                    end
                    PH_MATCHEXT: begin
                        match_left = sat_add(match_left, {24'd0, b});
                        if (b != BYTE_EXT) start_copy(match_left);
                    end
                    default: r.accepted = 1'b0;
                endcase
            end
        end
        close_if_done();
        r.copy_pending = (ph == PH_COPY && fin_st == ST_RUN);
        r.status = fin_st;
        results_due.push_back(r);
    endtask

    always @(posedge i_clk) begin
        logic fire;
        logic next_valid;
        fire = i_s_tvalid && o_s_tready;
        next_valid = i_s_tvalid && !fire;
        if (fire) begin
            decode_step(cur_req.op, cur_req.data);
            accepted_reqs++;
        end
        if (i_rst_n && !next_valid) begin
            if (gap_left > 0) begin
                gap_left--;
            end else if (compressed_stream.size() > 0) begin
                cur_req = compressed_stream.pop_front();
                i_s_tdata <= cur_req.data;
                i_s_tuser <= cur_req.op;
                next_valid = 1'b1;
                if (burst_left > 0) begin
                    burst_left--;
                end else begin
                    burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(40, 120)
                                                             : $urandom_range(1, 16);
                    gap_left = $urandom_range(0, 6);
                end
            end
        end
        drive_busy = next_valid;
        i_s_tvalid <= next_valid;
    end

    always @(posedge i_clk) begin
        stall_tick++;
        if (stall_tick % 50 == 0) stall_mode = $urandom_range(0, 4);
        case (stall_mode)
            0: i_m_tready <= 1'b1;
            1: i_m_tready <= ($urandom_range(0, 3) != 0);
            2: i_m_tready <= ($urandom_range(0, 1) == 1);
            3: i_m_tready <= ($urandom_range(0, 7) == 0);
            default: i_m_tready <= stall_tick[2];
        endcase
    end

    always @(posedge i_clk) begin
        t_lz4_result want;
        logic [1:0]  got_status;
        if (i_rst_n && o_m_tvalid && i_m_tready) begin
            got_status = o_m_tdata[OUT_STATUS_LO +: 2];
            if (results_due.size() == 0) begin
                log_mismatch($sformatf("result 0x%h with nothing pending", o_m_tdata));
            end else begin
                want = results_due.pop_front();
                if (o_m_tdata[OUT_VALID_BIT] !== want.out_valid)
                    log_mismatch($sformatf("out_valid %b, want %b",
                                           o_m_tdata[OUT_VALID_BIT], want.out_valid));
                if (o_m_tdata[OUT_BYTE_LO +: 8] !== want.out_byte)
                    log_mismatch($sformatf("out_byte 0x%h, want 0x%h",
                                           o_m_tdata[OUT_BYTE_LO +: 8], want.out_byte));
                if (o_m_tdata[OUT_ACC_BIT] !== want.accepted)
                    log_mismatch($sformatf("accepted %b, want %b",
                                           o_m_tdata[OUT_ACC_BIT], want.accepted));
                if (o_m_tdata[OUT_PEND_BIT] !== want.copy_pending)
                    log_mismatch($sformatf("copy_pending %b, want %b",
                                           o_m_tdata[OUT_PEND_BIT], want.copy_pending));
                if (got_status !== want.status)
                    log_mismatch($sformatf("status %b, want %s", got_status, want.status.name()));
            end
        end
    end

    always @(posedge i_clk) begin
        cycles++;
        if (cycles > CYCLE_LIMIT) begin
            $display("Timeout after %0d cycles, %0d results outstanding", cycles,
                     results_due.size());
            $display("Some tests failed");
            $finish;
        end
    end

    task push_req(input logic op, input logic [7:0] data);
        t_lz4_req q;
        q.op = op;
        q.data = data;
        compressed_stream.push_back(q);
    endtask

    task queue_byte(input logic [7:0] b);
        if ($urandom_range(0, 7) == 0) push_req(OP_ADVANCE, 8'($urandom_range(0, 255)));
        push_req(OP_BYTE, b);
        real_reqs++;
    endtask

    task queue_advance;
        if ($urandom_range(0, 7) == 0) push_req(OP_BYTE, 8'($urandom_range(0, 255)));
        push_req(OP_ADVANCE, 8'($urandom_range(0, 255)));
        real_reqs++;
    endtask

    task queue_length_tail(input int rem);
        while (rem >= 255) begin
            queue_byte(BYTE_EXT);
            rem -= 255;
        end
        queue_byte(rem[7:0]);
    endtask

    task queue_sequence(input int lit_len, input bit with_match, input int match_extra,
                        input int offset_val);
        int lit_nib;
        int m_nib;
        lit_nib = (lit_len >= 15) ? 15 : lit_len;
        m_nib = (match_extra >= 15) ? 15 : match_extra;
        queue_byte({lit_nib[3:0], m_nib[3:0]});
        if (lit_len >= 15) queue_length_tail(lit_len - 15);
        repeat (lit_len) queue_byte(8'($urandom_range(0, 255)));
        gen_count += lit_len;
        if (with_match) begin
            queue_byte(offset_val[7:0]);
            queue_byte(offset_val[15:8]);
            if (offset_val != 0) begin
                if (match_extra >= 15) queue_length_tail(match_extra - 15);
                repeat (match_extra + 4) queue_advance();
                gen_count += match_extra + 4;
            end
        end
    endtask

    task queue_random_sequence(input bit long_lit, input bit long_match);
        int lit_len;
        int extra;
        int avail;
        int offset_val;
        case ($urandom_range(0, 3))
            0, 1: lit_len = $urandom_range(0, 14);
            2: lit_len = $urandom_range(15, 40);
            default: lit_len = $urandom_range(0, 3);
        endcase
        if (long_lit) lit_len = 270 + $urandom_range(0, 6);
        extra = ($urandom_range(0, 2) == 0) ? $urandom_range(15, 40) : $urandom_range(0, 14);
        if (long_match) extra = 270 + $urandom_range(0, 6);
        avail = gen_count + lit_len;
        if (avail > 65535) avail = 65535;
        if ($urandom_range(0, 2) == 0) offset_val = $urandom_range(1, (avail < 4) ? avail : 4);
        else offset_val = $urandom_range(1, avail);
        queue_sequence(lit_len, 1'b1, extra, offset_val);
        sequences++;
    endtask

    task wait_idle;
        while (compressed_stream.size() != 0 || drive_busy || results_due.size() != 0)
            @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    task write_total(input logic [31:0] value);
        @(posedge i_clk);
        i_cfg_we <= 1'b1;
        i_cfg_wdata <= value;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        total_reg = value;
        cfg_writes++;
    endtask

    initial begin
        t_end_kind end_kind;
        int lit_len;
        int target;
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        write_total(32'hFFFF_FFFF);

        push_req(OP_ADVANCE, 8'hFF);
        queue_byte(8'h20);
        queue_byte(8'h00);
        queue_byte(8'hFF);
        gen_count += 2;
        queue_byte(8'h01);
        queue_byte(8'h00);
        queue_advance();
        push_req(OP_BYTE, 8'hA5);
        repeat (3) queue_advance();
        gen_count += 4;
        queue_sequence(0, 1'b1, 0, 3);
        queue_sequence(1, 1'b1, 15, gen_count + 1);
        wait_idle();

        for (int p = 0; p < 3; p++) begin
            case (p)
                0: write_total(32'hFFFF_FFFF);
                1: write_total($urandom_range(32'h0100_0000, 32'hFFFF_FFFE));
                default: write_total(32'h8000_0000 | $urandom);
            endcase
            queue_random_sequence(p == 2, p == 1);
            target = 330 * (p + 1);
            while (real_reqs < target) queue_random_sequence(1'b0, 1'b0);
            wait_idle();
        end

        end_kind = t_end_kind'($urandom_range(0, 3));
        case (end_kind)
            END_EXACT: begin
                lit_len = $urandom_range(1, 14);
                write_total(gen_count + lit_len);
                queue_sequence(lit_len, 1'b0, 0, 0);
            end
            END_OVERRUN: begin
                lit_len = $urandom_range(2, 14);
                write_total(gen_count + 1);
                queue_sequence(lit_len, 1'b0, 0, 0);
            end
            END_ZERO_OFFSET: begin
                queue_sequence($urandom_range(0, 3), 1'b1, $urandom_range(0, 20), 0);
            end
            default: begin
                write_total(32'd0);
            end
        endcase
        repeat (6) push_req(1'($urandom_range(0, 1)), 8'($urandom_range(0, 255)));
        wait_idle();
        write_total(32'hFFFF_FFFF);
        repeat (3) push_req(1'($urandom_range(0, 1)), 8'($urandom_range(0, 255)));

        while (compressed_stream.size() != 0 || drive_busy || results_due.size() != 0)
            @(posedge i_clk);
        repeat (8) @(posedge i_clk);

        $display("Checked %0d requests (%0d decoded bytes, %0d sequences) over %0d writes",
                 accepted_reqs, produced, sequences, cfg_writes);
        $display("of output_total, with stalls on both streams; run ended as %s (%s).",
                 fin_st.name(), end_kind.name());
        if (errors == 0) begin
            $display("All tests passed");
        end else begin
            $display("Some tests failed");
        end
        $finish;
    end

endmodule
`default_nettype wire

FILE: files.f
+incdir+hw/rtl
hw/rtl/lz4bd_pkg.sv
hw/rtl/lz4bd_window.sv
hw/rtl/lz4_block_decoder.sv
hw/rtl/lz4bd_checker.sv
tb/sv/lz4_block_decoder_tb.sv
